// ----- src/lpg_pkg.sv -----
// Shared types and constants for the line pixel generator.
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int COLOR_BITS     = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int SCREEN_W_RST   = 128;
  localparam int SCREEN_H_RST   = 160;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Width of one queued command: op, two signs, six coordinates/spans, error, color.
  function automatic int entry_bits(input int cb);
    return 7 * cb + 5 + COLOR_BITS;
  endfunction

endpackage

// ----- src/lpg_if.sv -----
// Handshake channels: pixel commands in, pixels out, configuration writes.
`timescale 1ns / 1ps

interface lpg_in_if #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  lpg_pkg::op_e                    operation;
  logic [COORD_BITS-1:0]           x_start;
  logic [COORD_BITS-1:0]           y_start;
  logic [COORD_BITS-1:0]           x_end;
  logic [COORD_BITS-1:0]           y_end;
  logic [lpg_pkg::COLOR_BITS-1:0]  color;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, color,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, color,
                  output ready);
endinterface

interface lpg_out_if #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS-1:0]           pixel_x;
  logic [COORD_BITS-1:0]           pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0]  pixel_color;
  logic                            on_screen;
  logic                            last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
                  output ready);
endinterface

interface lpg_cfg_if #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [lpg_pkg::CFG_IDX_BITS-1:0]  index;
  logic [COORD_BITS:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/lpg_front.sv -----
// Front end: accepts command items and precomputes spans, signs and initial error.
`timescale 1ns / 1ps

module lpg_front #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = lpg_pkg::entry_bits(COORD_BITS)
) (
  lpg_in_if.sink              in_i,
  input  lpg_pkg::q_status_t  q_stat_i,
  output logic                push_o,
  output logic [ENTRY_W-1:0]  entry_o
);

  typedef struct packed {
    lpg_pkg::op_e                    op;
    logic                            step_left;
    logic                            step_up;
    logic [COORD_BITS-1:0]           xs;
    logic [COORD_BITS-1:0]           ys;
    logic [COORD_BITS-1:0]           xe;
    logic [COORD_BITS-1:0]           ye;
    logic [COORD_BITS-1:0]           span_x;
    logic [COORD_BITS-1:0]           span_y;
    logic signed [COORD_BITS+1:0]    err;
    logic [lpg_pkg::COLOR_BITS-1:0]  color;
  } entry_t;

  entry_t ent;

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    ent           = '0;
    ent.op        = in_i.operation;
    ent.xs        = in_i.x_start;
    ent.ys        = in_i.y_start;
    ent.xe        = in_i.x_end;
    ent.ye        = in_i.y_end;
    ent.color     = in_i.color;
    ent.step_left = !(in_i.x_start < in_i.x_end);
    ent.step_up   = !(in_i.y_start < in_i.y_end);
    ent.span_x    = ent.step_left ? (in_i.x_start - in_i.x_end) : (in_i.x_end - in_i.x_start);
    ent.span_y    = ent.step_up ? (in_i.y_start - in_i.y_end) : (in_i.y_end - in_i.y_start);
    ent.err       = $signed({2'b00, ent.span_x}) - $signed({2'b00, ent.span_y});
  end

  assign entry_o = ent;

endmodule

// ----- src/lpg_queue.sv -----
// Small register queue between front end and pixel stepper.
`timescale 1ns / 1ps

module lpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output lpg_pkg::q_status_t  status_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ----- src/lpg_back.sv -----
// Back end: Bresenham stepper, screen size registers and output register.
`timescale 1ns / 1ps

module lpg_back #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = lpg_pkg::entry_bits(COORD_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ENTRY_W-1:0]  entry_i,
  input  lpg_pkg::q_status_t  q_stat_i,
  output logic                pop_o,
  lpg_cfg_if.sink             cfg_i,
  lpg_out_if.source           out_o
);

  localparam int CB   = COORD_BITS;
  localparam int ErrW = COORD_BITS + 2;

  typedef struct packed {
    lpg_pkg::op_e                    op;
    logic                            step_left;
    logic                            step_up;
    logic [CB-1:0]                   xs;
    logic [CB-1:0]                   ys;
    logic [CB-1:0]                   xe;
    logic [CB-1:0]                   ye;
    logic [CB-1:0]                   span_x;
    logic [CB-1:0]                   span_y;
    logic signed [ErrW-1:0]          err;
    logic [lpg_pkg::COLOR_BITS-1:0]  color;
  } entry_t;

  entry_t ent;

  // Line state
  logic [CB-1:0]                   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB-1:0]                   tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CB-1:0]                   span_x_q, span_x_d, span_y_q, span_y_d;
  logic signed [ErrW-1:0]          err_q, err_d;
  logic                            left_q, left_d, up_q, up_d;
  logic [lpg_pkg::COLOR_BITS-1:0]  color_q, color_d;
  logic                            active_q, active_d;

  logic [CB:0] scr_w_q, scr_h_q;

  // Output register
  logic                            ovalid_q, ovalid_d;
  logic [CB-1:0]                   ox_q, oy_q;
  logic [lpg_pkg::COLOR_BITS-1:0]  ocolor_q;
  logic                            oon_q, olast_q;

  logic                   can_go, emit, last, on_scr, move_x, move_y;
  logic signed [ErrW:0]   e2, ndy, dx, err_sum;

  assign ent         = entry_i;
  assign cfg_i.ready = 1'b1;
  assign can_go      = !ovalid_q || out_o.ready;
  assign pop_o       = !q_stat_i.empty && can_go;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    err_d    = err_q;
    left_d   = left_q;
    up_d     = up_q;
    color_d  = color_q;
    active_d = active_q;
    emit     = 1'b0;

    e2      = {err_q, 1'b0};
    ndy     = -$signed({1'b0, 2'b00, span_y_q});
    dx      = $signed({1'b0, 2'b00, span_x_q});
    move_x  = (e2 >= ndy);
    move_y  = (e2 <= dx);
    err_sum = {err_q[ErrW-1], err_q} + (move_x ? ndy : '0) + (move_y ? dx : '0);

    if (pop_o) begin
      unique case (ent.op)
        lpg_pkg::OP_START: begin
          cur_x_d  = ent.xs;
          cur_y_d  = ent.ys;
          tgt_x_d  = ent.xe;
          tgt_y_d  = ent.ye;
          span_x_d = ent.span_x;
          span_y_d = ent.span_y;
          err_d    = ent.err;
          left_d   = ent.step_left;
          up_d     = ent.step_up;
          color_d  = ent.color;
          emit     = 1'b1;
        end
        lpg_pkg::OP_STEP: begin
          // Drop steps that arrive with no line in progress.
          if (active_q) begin
            err_d = err_sum[ErrW-1:0];
            if (move_x) cur_x_d = left_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
            if (move_y) cur_y_d = up_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
            emit = 1'b1;
          end
        end
        default: ;
      endcase
    end

    last   = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
    on_scr = ({1'b0, cur_x_d} < scr_w_q) && ({1'b0, cur_y_d} < scr_h_q);
    if (emit) active_d = !last;
    ovalid_d = can_go ? emit : ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      err_q    <= '0;
      left_q   <= 1'b0;
      up_q     <= 1'b0;
      color_q  <= '0;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      scr_w_q  <= (CB+1)'(lpg_pkg::SCREEN_W_RST);
      scr_h_q  <= (CB+1)'(lpg_pkg::SCREEN_H_RST);
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      err_q    <= err_d;
      left_q   <= left_d;
      up_q     <= up_d;
      color_q  <= color_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          lpg_pkg::CFG_SCREEN_WIDTH:  scr_w_q <= cfg_i.data;
          lpg_pkg::CFG_SCREEN_HEIGHT: scr_h_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_go && emit) begin
      ox_q     <= cur_x_d;
      oy_q     <= cur_y_d;
      ocolor_q <= color_d;
      oon_q    <= on_scr;
      olast_q  <= last;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.pixel_x     = ox_q;
  assign out_o.pixel_y     = oy_q;
  assign out_o.pixel_color = ocolor_q;
  assign out_o.on_screen   = oon_q;
  assign out_o.last_pixel  = olast_q;

endmodule

// ----- src/line_pixel_generator.sv -----
// An accepted command item is written into the queue first, then popped by the stepper into
// the output register; output back-pressure can hold it in the queue between the two.
// Throughput: one item per cycle while the output is not stalled; each Bresenham step is one stepper pass.
// A two-entry queue between front end and stepper absorbs output stalls.
// Reset clears the queue, the output valid and the line state (no line active);
// screen size comes out of reset as 128 columns by 160 rows.
`timescale 1ns / 1ps

module line_pixel_generator #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
  parameter int Q_DEPTH    = lpg_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpg_in_if.sink     in_i,
  lpg_cfg_if.sink    cfg_i,
  lpg_out_if.source  out_o
);

  localparam int EntryW = lpg_pkg::entry_bits(COORD_BITS);

  lpg_pkg::q_status_t q_stat;
  logic               push, pop;
  logic [EntryW-1:0]  push_data, pop_data;

  lpg_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (EntryW)
  ) u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_data)
  );

  lpg_queue #(
    .WIDTH (EntryW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .data_o   (pop_data),
    .status_o (q_stat)
  );

  lpg_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (EntryW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (pop_data),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .cfg_i    (cfg_i),
    .out_o    (out_o)
  );

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("stepper popped an empty queue");

endmodule
